/* design/ahsc_pkg.sv */
package ahsc_pkg;

	localparam int CAPACITY_DEF = 4096;
	localparam int LEVELS_DEF   = 64;
	localparam int HASH_W       = 64;
	localparam int LVL_W        = 7;
	localparam int ELVL_W       = 6;
	localparam int CNT_W        = 32;
	localparam int TOT_W        = 13;
	localparam int KMER_W       = 64;
	localparam int QDEPTH       = 4;
	localparam logic [TOT_W-1:0] MAX_SAMPLES_RST = 13'd4096;
	localparam logic [LVL_W-1:0] LVL_CEIL        = 7'd64;

	// One queued item: hash, its level and the running hash count.
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [LVL_W-1:0]  level;
		logic [KMER_W-1:0] kmers;
	} ahsc_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ahsc_qstat_t;

	// Sample table entry; used is cleared once after reset, never again.
	typedef struct packed {
		logic              used;
		logic [HASH_W-1:0] hash;
		logic [ELVL_W-1:0] level;
		logic [CNT_W-1:0]  cnt;
	} ahsc_entry_t;

	// Trailing zero count, 64 for a zero hash: per-byte encode, then byte pick.
	function automatic logic [LVL_W-1:0] ctz64(input logic [HASH_W-1:0] h);
		logic [7:0]       nz;
		logic [2:0]       bz [8];
		logic [LVL_W-1:0] r;
		for (int b = 0; b < 8; b++) begin
			nz[b] = |h[8*b +: 8];
			bz[b] = 3'd0;
			for (int i = 7; i >= 0; i--) begin
				if (h[8*b + i]) begin
					bz[b] = 3'(i);
				end
			end
		end
		r = LVL_CEIL;
		for (int b = 7; b >= 0; b--) begin
			if (nz[b]) begin
				r = {1'b0, 3'(b), bz[b]};
			end
		end
		return r;
	endfunction

endpackage

/* design/ahsc_front.sv */
module ahsc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [63:0]            hash_value,
	input  ahsc_pkg::ahsc_qstat_t  qstat,
	output logic                   push,
	output ahsc_pkg::ahsc_item_t   push_item
);
	import ahsc_pkg::*;

	logic [KMER_W-1:0] kmer_q;

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	assign push_item.hash  = hash_value;
	assign push_item.level = ctz64(hash_value);
	assign push_item.kmers = kmer_q + KMER_W'(1);

	// count every accepted item, wrapping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q <= '0;
		end else if (push) begin
			kmer_q <= kmer_q + KMER_W'(1);
		end
	end

endmodule

/* design/ahsc_fifo.sv */
module ahsc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ahsc_pkg::ahsc_item_t  push_item,
	input  logic                  pop,
	output ahsc_pkg::ahsc_item_t  head,
	output ahsc_pkg::ahsc_qstat_t qstat
);
	import ahsc_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	ahsc_item_t       slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == (PTR_W+1)'(QDEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

/* design/ahsc_back.sv */
module ahsc_back #(
	parameter int CAPACITY = ahsc_pkg::CAPACITY_DEF,
	parameter int LEVELS   = ahsc_pkg::LEVELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [12:0]           limit_raw,
	input  ahsc_pkg::ahsc_qstat_t qstat,
	input  ahsc_pkg::ahsc_item_t  head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  sampled,
	output logic                  was_new,
	output logic [6:0]            hash_level,
	output logic [31:0]           sample_frequency,
	output logic [6:0]            threshold_now,
	output logic [12:0]           samples_held,
	output logic [63:0]           kmers_seen
);
	import ahsc_pkg::*;

	localparam int IDXW = $clog2(CAPACITY);
	localparam int LA   = $clog2(LEVELS);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_PROBE = 8'b0000_0100,
		ST_CHECK = 8'b0000_1000,
		ST_INS   = 8'b0001_0000,
		ST_LINC  = 8'b0010_0000,
		ST_DCHK  = 8'b0100_0000,
		ST_DROP  = 8'b1000_0000
	} st_t;

	function automatic logic [IDXW-1:0] home_of(input logic [HASH_W-1:0] h);
		logic [IDXW-1:0] f;
		f = '0;
		for (int i = 0; i < HASH_W; i++) begin
			f[i % IDXW] = f[i % IDXW] ^ h[i];
		end
		if ({1'b0, f} >= (IDXW+1)'(CAPACITY)) begin
			f = IDXW'({1'b0, f} - (IDXW+1)'(CAPACITY));
		end
		return f;
	endfunction

	st_t              st_q;
	ahsc_item_t       cur_q;
	logic [IDXW-1:0]  idx_q, probes_q, tomb_idx_q, ins_idx_q;
	logic             tomb_vld_q;
	logic [LVL_W-1:0] thr_q;
	logic [TOT_W-1:0] total_q;

	ahsc_entry_t      tbl_mem [CAPACITY];
	ahsc_entry_t      tbl_rd_q, tbl_wdata;
	logic             tbl_we;
	logic [IDXW-1:0]  tbl_waddr;

	logic [TOT_W-1:0] lvl_mem [LEVELS];
	logic             lvl_vld_q [LEVELS];
	logic [TOT_W-1:0] lvl_rd_q;
	logic             lvl_rdv_q;
	logic [LA-1:0]    lvl_raddr;
	logic [TOT_W-1:0] lvl_size;

	logic             out_load;
	logic             o_sampled, o_new;
	logic [CNT_W-1:0] o_freq;

	logic [TOT_W-1:0] limit;
	logic             live, match, cand, last_probe;
	logic [CNT_W-1:0] cnt_next;
	logic [IDXW-1:0]  idx_next;

	assign limit      = (limit_raw == '0) ? TOT_W'(1) : limit_raw;
	assign live       = tbl_rd_q.used && ({1'b0, tbl_rd_q.level} >= thr_q);
	assign match      = live && (tbl_rd_q.hash == cur_q.hash);
	assign cnt_next   = (&tbl_rd_q.cnt) ? tbl_rd_q.cnt : tbl_rd_q.cnt + CNT_W'(1);
	assign last_probe = (probes_q == LAST_IDX);
	assign idx_next   = (idx_q == LAST_IDX) ? '0 : idx_q + IDXW'(1);
	assign cand       = (head.level < LVL_W'(LEVELS)) && (head.level >= thr_q);
	assign pop        = (st_q == ST_IDLE) && !qstat.empty && (!out_valid || !out_stall);
	assign lvl_raddr  = (st_q == ST_DCHK) ? thr_q[LA-1:0] : cur_q.level[LA-1:0];
	assign lvl_size   = lvl_rdv_q ? lvl_rd_q : '0;

	// table write port: clearing pass, count update or insert
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = idx_q;
		tbl_wdata = '0;
		unique case (st_q)
			ST_CLEAR: tbl_we = 1'b1;
			ST_CHECK: begin
				if (match) begin
					tbl_we         = 1'b1;
					tbl_wdata      = tbl_rd_q;
					tbl_wdata.cnt  = cnt_next;
				end
			end
			ST_INS: begin
				tbl_we          = 1'b1;
				tbl_waddr       = ins_idx_q;
				tbl_wdata.used  = 1'b1;
				tbl_wdata.hash  = cur_q.hash;
				tbl_wdata.level = cur_q.level[ELVL_W-1:0];
				tbl_wdata.cnt   = CNT_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		tbl_rd_q <= tbl_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_LINC) begin
			lvl_mem[cur_q.level[LA-1:0]] <= lvl_size + TOT_W'(1);
		end
		lvl_rd_q <= lvl_mem[lvl_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				lvl_vld_q[i] <= 1'b0;
			end
			lvl_rdv_q <= 1'b0;
		end else begin
			lvl_rdv_q <= lvl_vld_q[lvl_raddr];
			if (st_q == ST_LINC) begin
				lvl_vld_q[cur_q.level[LA-1:0]] <= 1'b1;
			end else if (st_q == ST_DROP) begin
				lvl_vld_q[thr_q[LA-1:0]] <= 1'b0;
			end
		end
	end

	// result selection for the finishing cycle
	always_comb begin
		out_load  = 1'b0;
		o_sampled = 1'b0;
		o_new     = 1'b0;
		o_freq    = '0;
		unique case (st_q)
			ST_IDLE: out_load = pop && !cand;
			ST_CHECK: begin
				if (match) begin
					out_load  = 1'b1;
					o_sampled = 1'b1;
					o_freq    = cnt_next;
				end else if (tbl_rd_q.used && last_probe && live && !tomb_vld_q) begin
					out_load = 1'b1;
				end
			end
			ST_DCHK: begin
				if (!(total_q >= limit && thr_q < LVL_CEIL)) begin
					out_load  = 1'b1;
					o_sampled = 1'b1;
					o_new     = 1'b1;
					o_freq    = CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			idx_q      <= '0;
			probes_q   <= '0;
			tomb_vld_q <= 1'b0;
			thr_q      <= '0;
			total_q    <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					idx_q <= idx_next;
					if (idx_q == LAST_IDX) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && cand) begin
						idx_q      <= home_of(head.hash);
						probes_q   <= '0;
						tomb_vld_q <= 1'b0;
						st_q       <= ST_PROBE;
					end
				end
				ST_PROBE: st_q <= ST_CHECK;
				ST_CHECK: begin
					priority if (match) begin
						st_q <= ST_IDLE;
					end else if (!tbl_rd_q.used) begin
						st_q <= ST_INS;
					end else begin
						if (!live && !tomb_vld_q) begin
							tomb_vld_q <= 1'b1;
						end
						if (last_probe) begin
							st_q <= (tomb_vld_q || !live) ? ST_INS : ST_IDLE;
						end else begin
							idx_q    <= idx_next;
							probes_q <= probes_q + IDXW'(1);
							st_q     <= ST_PROBE;
						end
					end
				end
				ST_INS: st_q <= ST_LINC;
				ST_LINC: begin
					total_q <= total_q + TOT_W'(1);
					st_q    <= ST_DCHK;
				end
				ST_DCHK: st_q <= (total_q >= limit && thr_q < LVL_CEIL) ? ST_DROP : ST_IDLE;
				ST_DROP: begin
					total_q <= total_q - ((lvl_size <= total_q) ? lvl_size : total_q);
					thr_q   <= thr_q + LVL_W'(1);
					st_q    <= ST_DCHK;
				end
				default: st_q <= ST_CLEAR;
			endcase
		end
	end

	// item capture, insert target and first reusable slot
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (st_q == ST_CHECK) begin
			if (tbl_rd_q.used && !live && !tomb_vld_q) begin
				tomb_idx_q <= idx_q;
			end
			ins_idx_q <= tomb_vld_q ? tomb_idx_q : idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sampled          <= o_sampled;
			was_new          <= o_new;
			sample_frequency <= o_freq;
			threshold_now    <= thr_q;
			samples_held     <= total_q;
			if (st_q == ST_IDLE) begin
				hash_level <= head.level;
				kmers_seen <= head.kmers;
			end else begin
				hash_level <= cur_q.level;
				kmers_seen <= cur_q.kmers;
			end
		end
	end

endmodule

/* design/adaptive_hash_sampling_counter_core.sv */
// Flow: an item below the threshold or at level LEVELS or above goes straight
//   to the output register; others walk PROBE and CHECK per table probe, then
//   INS, LINC and DCHK for an insert and DROP and DCHK per dropped level.
// Throughput: one item at a time in the back end's linear-probing table walk.
// Reset: async active low; clears counters, threshold and total, then a clearing
//   pass over all CAPACITY slots marks each one unused before items proceed.
module adaptive_hash_sampling_counter_core #(
	parameter int CAPACITY = ahsc_pkg::CAPACITY_DEF,
	parameter int LEVELS   = ahsc_pkg::LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] hash_value,
	// max_samples register
	input  logic        max_samples_we,
	input  logic [12:0] max_samples,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sampled,
	output logic        was_new,
	output logic [6:0]  hash_level,
	output logic [31:0] sample_frequency,
	output logic [6:0]  threshold_now,
	output logic [12:0] samples_held,
	output logic [63:0] kmers_seen
);
	import ahsc_pkg::*;

	logic [TOT_W-1:0] max_samples_q;
	ahsc_qstat_t      qstat;
	ahsc_item_t       push_item, head;
	logic             push, pop;

	// Config register; to be written only while idle, unchecked by the block; zero acts as one in the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_samples_q <= MAX_SAMPLES_RST;
		end else if (max_samples_we) begin
			max_samples_q <= max_samples;
		end
	end

	// Front end: take an item, find its level, number it.
	ahsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.hash_value(hash_value),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	// Short queue decouples accept from the table walk.
	ahsc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// Back end: lookup/insert, level bookkeeping, drops, output register.
	ahsc_back #(
		.CAPACITY(CAPACITY),
		.LEVELS  (LEVELS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.limit_raw       (max_samples_q),
		.qstat           (qstat),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sampled         (sampled),
		.was_new         (was_new),
		.hash_level      (hash_level),
		.sample_frequency(sample_frequency),
		.threshold_now   (threshold_now),
		.samples_held    (samples_held),
		.kmers_seen      (kmers_seen)
	);

endmodule

/* design/ahsc_checker.sv */
module ahsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        sampled,
	input logic        was_new,
	input logic [6:0]  hash_level,
	input logic [31:0] sample_frequency,
	input logic [6:0]  threshold_now
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_frequency) && $stable(sampled))
		else $error("stalled item changed");

	a_new_sampled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_new |-> sampled && sample_frequency == 32'd1)
		else $error("new item not reported as sampled once");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sampled |-> !was_new && sample_frequency == 32'd0)
		else $error("unsampled item carries a count");

	a_zero_hash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hash_level == 7'd64 |-> !sampled)
		else $error("zero hash sampled");

	a_hit_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sampled && !was_new |-> hash_level >= threshold_now && sample_frequency != 32'd0)
		else $error("hit below threshold");

endmodule

bind adaptive_hash_sampling_counter_core ahsc_checker u_ahsc_checker (.*);
